### design/stpg_pkg.sv
// shared types and constants for the step trigger pattern generator
package stpg_pkg;

  localparam int CfgDataW = 16;
  localparam int CfgIdxW  = 2;
  localparam int PtrW     = 9;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_START_EDGE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FPS         = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_REPEATS     = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_STEP_COUNT  = 2'd3;

  // input commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // pattern region, also reported on the output word
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_PAD  = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef struct packed {
    logic        command;
    logic [7:0]  step_index;
    logic [15:0] step_gap;
  } in_word_t;

  typedef struct packed {
    logic   level;
    phase_t region;
    logic   last;
  } out_word_t;

endpackage

### design/step_trigger_pattern_generator.sv
// top level of the step trigger pattern generator
//
// usage
// - input channel in_valid / in_stall / in_data carries load and tick words;
//   a word is taken on a rising edge with in_valid high and in_stall low
// - a load word writes step_gap into the step table at step_index; it gives
//   no output word
// - a tick word gives exactly one output word (level, region, last) on
//   out_valid / out_data, held until a cycle with out_stall low
// - a tick sets out_valid once any segments skipped in place and any
//   step-table fetches (a step pointer advance or the wrap at the end of a
//   repeat) are done; at most two fetches per tick
// - word flow: a new word is taken only when the single sequencer that
//   walks the segments is ready again; the step table memory has a
//   registered read
// - configuration: cfg_we, cfg_index, cfg_data write a register; any write
//   restarts the pattern at the start of idle and keeps the step table
// - reset (rst, synchronous) restores register defaults and restarts the
//   pattern; the step table is not cleared and an entry must be loaded
//   before the pattern reaches it
// - while the output word is stalled no further tick or load is taken
module step_trigger_pattern_generator #(
  parameter int STEP_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  stpg_pkg::in_word_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output stpg_pkg::out_word_t               out_data,
  input  logic                              cfg_we,
  input  logic [stpg_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [stpg_pkg::CfgDataW-1:0]     cfg_data
);
  import stpg_pkg::*;

  localparam int AW = (STEP_DEPTH > 1) ? $clog2(STEP_DEPTH) : 1;

  // sequencer states
  typedef enum logic [3:0] {
    SQ_READY = 4'b0001,
    SQ_EVAL  = 4'b0010,
    SQ_FETCH = 4'b0100,
    SQ_CAPT  = 4'b1000
  } seq_t;

  // configuration registers
  logic [15:0]     start_edge;
  logic [15:0]     frames_per_slice;
  logic [15:0]     repeats;
  logic [PtrW-1:0] step_count;

  // pattern state
  seq_t            seq, seq_next;
  phase_t          phase, phase_next;
  logic [PtrW-1:0] ptr, ptr_next;
  logic            pulse, pulse_next;
  logic [15:0]     gc, gc_next;       // whole frame groups in the segment
  logic [15:0]     sc, sc_next;       // samples within the current group
  logic [15:0]     rep, rep_next;
  logic [15:0]     cur_gap;           // table entry at ptr
  logic            gap0_zero;         // table entry 0 is zero

  // step table memory, one write and one registered read port
  logic [15:0]     mem [STEP_DEPTH];
  logic [15:0]     rd_data;

  logic [15:0]     f_eff;
  logic [PtrW-1:0] n_eff;
  logic [31:0]     ld_idx_ext, ptr_ext;
  logic [AW-1:0]   ld_addr, ptr_addr;
  logic            ld_ok, accept, tick_acc, ld_acc;
  logic            in_step, seg_end, emit;
  out_word_t       emit_word;

  // zero frames per slice acts as one; step count clipped to the table
  assign f_eff = (frames_per_slice == 16'd0) ? 16'd1 : frames_per_slice;
  assign n_eff = (32'(step_count) > 32'(STEP_DEPTH)) ? PtrW'(STEP_DEPTH) : step_count;

  assign ld_idx_ext = 32'(in_data.step_index);
  assign ld_ok      = ld_idx_ext < 32'(STEP_DEPTH);
  assign ld_addr    = ld_idx_ext[AW-1:0];
  assign ptr_ext    = 32'(ptr);
  assign ptr_addr   = ptr_ext[AW-1:0];

  // take words only when idle and the output slot is free or draining
  assign in_stall = (seq != SQ_READY) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign tick_acc = accept && (in_data.command == CMD_TICK);
  assign ld_acc   = accept && (in_data.command == CMD_LOAD);

  // current body segment finished: low gap, high pulse, or closing tail
  assign in_step = ptr < n_eff;
  always_comb begin
    if (in_step) begin
      seg_end = pulse ? (gc != 16'd0) : (gc >= cur_gap);
    end else begin
      seg_end = gap0_zero ? (gc != 16'd0) : 1'b1;
    end
  end

  // one segment decision per cycle in the evaluate state; emits when a sample is due
  always_comb begin
    seq_next   = seq;
    phase_next = phase;
    ptr_next   = ptr;
    pulse_next = pulse;
    gc_next    = gc;
    sc_next    = sc;
    rep_next   = rep;
    emit       = 1'b0;
    emit_word  = '{level: 1'b0, region: PH_DONE, last: 1'b0};
    case (seq)
      SQ_READY: begin
        if (tick_acc) begin
          seq_next = SQ_EVAL;
        end
      end
      SQ_EVAL: begin
        if (n_eff == '0) begin
          // empty table use: done at once
          phase_next = PH_DONE;
          emit       = 1'b1;
        end else begin
          case (phase)
            PH_IDLE: begin
              if (gc >= start_edge) begin
                phase_next = PH_BODY;
                ptr_next   = '0;
                pulse_next = 1'b0;
                gc_next    = '0;
                sc_next    = '0;
                rep_next   = '0;
                seq_next   = SQ_FETCH;
              end else begin
                emit             = 1'b1;
                emit_word.level  = (gc >= start_edge - 16'd1);
                emit_word.region = PH_IDLE;
              end
            end
            PH_BODY: begin
              if (seg_end) begin
                gc_next = '0;
                sc_next = '0;
                if (in_step) begin
                  if (!pulse) begin
                    pulse_next = 1'b1;
                  end else begin
                    pulse_next = 1'b0;
                    ptr_next   = ptr + PtrW'(1);
                    seq_next   = SQ_FETCH;
                  end
                end else begin
                  // end of one repeat
                  ptr_next   = '0;
                  pulse_next = 1'b0;
                  seq_next   = SQ_FETCH;
                  if (repeats != 16'd0) begin
                    rep_next = rep + 16'd1;
                    if ((rep + 16'd1) >= repeats) begin
                      phase_next = PH_PAD;
                    end
                  end
                end
              end else begin
                emit             = 1'b1;
                emit_word.level  = in_step && pulse;
                emit_word.region = PH_BODY;
              end
            end
            PH_PAD: begin
              emit             = 1'b1;
              emit_word.region = PH_PAD;
              emit_word.last   = 1'b1;
              phase_next       = PH_DONE;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
        // idle and body samples advance the sample position
        if (emit && (phase == PH_IDLE || phase == PH_BODY) && n_eff != '0) begin
          if (sc == f_eff - 16'd1) begin
            sc_next = '0;
            gc_next = gc + 16'd1;
          end else begin
            sc_next = sc + 16'd1;
          end
        end
        if (emit) begin
          seq_next = SQ_READY;
        end
      end
      SQ_FETCH: seq_next = SQ_CAPT;
      SQ_CAPT:  seq_next = SQ_EVAL;
      default:  seq_next = SQ_READY;
    endcase
  end

  // step table: written by loads, read at the step pointer every cycle
  always_ff @(posedge clk) begin
    if (ld_acc && ld_ok) begin
      mem[ld_addr] <= in_data.step_gap;
    end
    rd_data <= mem[ptr_addr];
  end

  // cached entries, refreshed on fetch and forwarded from loads
  always_ff @(posedge clk) begin
    if (seq == SQ_CAPT) begin
      cur_gap <= rd_data;
    end else if (ld_acc && ld_ok && ld_addr == ptr_addr) begin
      cur_gap <= in_data.step_gap;
    end
    if (ld_acc && ld_ok && ld_addr == '0) begin
      gap0_zero <= (in_data.step_gap == 16'd0);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= emit_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq              <= SQ_READY;
      phase            <= PH_IDLE;
      ptr              <= '0;
      pulse            <= 1'b0;
      gc               <= '0;
      sc               <= '0;
      rep              <= '0;
      out_valid        <= 1'b0;
      start_edge       <= 16'd0;
      frames_per_slice <= 16'd1;
      repeats          <= 16'd1;
      step_count       <= '0;
    end else begin
      seq <= seq_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      // register write restarts the pattern
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_EDGE: start_edge       <= cfg_data;
          CFG_FPS:        frames_per_slice <= cfg_data;
          CFG_REPEATS:    repeats          <= cfg_data;
          CFG_STEP_COUNT: step_count       <= cfg_data[PtrW-1:0];
          default:        ;
        endcase
        phase <= PH_IDLE;
        ptr   <= '0;
        pulse <= 1'b0;
        gc    <= '0;
        sc    <= '0;
        rep   <= '0;
      end else begin
        phase <= phase_next;
        ptr   <= ptr_next;
        pulse <= pulse_next;
        gc    <= gc_next;
        sc    <= sc_next;
        rep   <= rep_next;
      end
    end
  end

  // done words carry no level and no last flag
  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.region == PH_DONE |-> !out_data.level && !out_data.last)
    else $error("done word with level or last set");

  // last marks only the end-pad word
  a_last_pad: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last |-> out_data.region == PH_PAD)
    else $error("last outside end pad");

  // sample position within a group stays below the group size
  a_sc_range: assert property (@(posedge clk) disable iff (rst)
    sc < f_eff)
    else $error("sample count beyond frame group");

  // step pointer never passes the step count in the body
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> ptr <= n_eff)
    else $error("step pointer beyond step count");

  // a fetch is always followed by the capture of the table entry
  a_fetch_capt: assert property (@(posedge clk) disable iff (rst)
    seq == SQ_FETCH |=> seq == SQ_CAPT)
    else $error("table fetch not captured");

endmodule
